@@ hw/rtl/hbs_pkg.sv @@
// ----------------------------------------------------------------------------
// hbs_pkg
// Shared types, constants and controller/datapath interface structs for the
// heightmap bilinear sampler.
// ----------------------------------------------------------------------------
package hbs_pkg;

  localparam int MAX_SIDE    = 128;
  localparam int SIDE_BITS   = 7;
  localparam int FRAC_BITS   = 8;
  localparam int HEIGHT_BITS = 16;
  localparam int ADDR_BITS   = 2 * SIDE_BITS;
  localparam int POS_BITS    = 16;
  localparam int WEIGHT_BITS = 2 * FRAC_BITS + 1;
  localparam int ACC_BITS    = HEIGHT_BITS + 2 * FRAC_BITS;
  localparam int GRID_BITS   = 8;
  localparam int CNT_BITS    = 3;

  localparam logic [GRID_BITS-1:0] GRID_RESET = 8'd128;
  localparam logic [GRID_BITS-1:0] GRID_MIN   = 8'd2;
  localparam logic [GRID_BITS-1:0] GRID_MAX   = 8'(MAX_SIDE);

  localparam logic [CNT_BITS-1:0] CNT_RD_LAST  = 3'd3;
  localparam logic [CNT_BITS-1:0] CNT_RUN_LAST = 3'd5;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam int REG_GRID_SIZE = 0;

  typedef struct packed {
    logic                          op;
    logic signed [POS_BITS-1:0]    pos_x;
    logic signed [POS_BITS-1:0]    pos_y;
    logic [SIDE_BITS-1:0]          write_row;
    logic [SIDE_BITS-1:0]          write_col;
    logic signed [HEIGHT_BITS-1:0] write_height;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] height;
    logic               in_range;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_DONE = 3'b100
  } state_t;

  typedef struct packed {
    logic       load;
    logic       mem_wr;
    logic       rd_en;
    logic [1:0] corner;
    logic       mul_en;
    logic       acc_en;
    logic       out_en;
  } cmd_t;

  typedef struct packed {
    logic in_range;
  } status_t;

endpackage

@@ hw/rtl/heightmap_bilinear_sampler_unit.sv @@
// ----------------------------------------------------------------------------
// heightmap_bilinear_sampler_unit
// A write transaction stores one height; busy stays low. A sample transaction
// holds busy through the RUN and DONE states (RUN is cut short when the cell
// is outside the grid): the four corners come one per cycle from the
// single-port 128x128 height memory and pass a registered multiply/accumulate
// pipeline. The result strobe out_valid, registered from DONE, rises for one
// cycle only, and a new transaction is taken in that same cycle.
// Results cannot be stalled. Only entries already written may be sampled.
// ----------------------------------------------------------------------------
module heightmap_bilinear_sampler_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  hbs_pkg::in_item_t     in_data,
  output logic                 out_valid,
  output hbs_pkg::out_item_t    out_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import hbs_pkg::*;

  logic [GRID_BITS-1:0] grid_size_r, grid_size_nxt;
  logic                 reg_sel;
  cmd_t                 cmd;
  status_t              status;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == 1'(REG_GRID_SIZE));

  always_comb begin
    grid_size_nxt = grid_size_r;
    if (psel && penable && pwrite && pready && reg_sel) begin
      grid_size_nxt = pwdata[GRID_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_size_r <= GRID_RESET;
    end else begin
      grid_size_r <= grid_size_nxt;
    end
  end

  assign prdata = reg_sel ? {{(32-GRID_BITS){1'b0}}, grid_size_r} : '0;

  hbs_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .op     (in_data.op),
    .status (status),
    .busy   (busy),
    .cmd    (cmd)
  );

  hbs_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .grid_size (grid_size_r),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

@@ hw/rtl/hbs_ctrl.sv @@
// ----------------------------------------------------------------------------
// hbs_ctrl
// Sequencer: accepts transactions, steps the four corner reads and the
// multiply/accumulate pipeline, and issues the result strobe.
// ----------------------------------------------------------------------------
module hbs_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic            op,
  input  hbs_pkg::status_t status,
  output logic            busy,
  output hbs_pkg::cmd_t    cmd
);
  import hbs_pkg::*;

  state_t              state_r, state_nxt;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                accept;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_IDLE: begin
        cnt_nxt = '0;
        if (accept && (op == OP_SAMPLE)) begin
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        cnt_nxt = cnt_r + 3'd1;
        if (!status.in_range || (cnt_r == CNT_RUN_LAST)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.load   = accept && (op == OP_SAMPLE);
    cmd.mem_wr = accept && (op == OP_WRITE);
    cmd.corner = cnt_r[1:0];
    if (state_r == S_RUN) begin
      cmd.rd_en  = (cnt_r <= CNT_RD_LAST);
      cmd.mul_en = (cnt_r inside {[3'd1:3'd4]});
      cmd.acc_en = (cnt_r inside {[3'd2:CNT_RUN_LAST]});
    end
    cmd.out_en = (state_r == S_DONE);
  end

  a_load_runs: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == S_RUN) && (cnt_r == 3'd0))
    else $error("sample accept did not enter RUN");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) |-> (cnt_r <= CNT_RUN_LAST))
    else $error("step counter overran");

  a_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mem_wr |-> !cmd.rd_en && !cmd.acc_en)
    else $error("memory write collides with sample work");

endmodule

@@ hw/rtl/hbs_dpath.sv @@
// ----------------------------------------------------------------------------
// hbs_dpath
// Height memory, cell/fraction split, weight and multiply/accumulate pipeline
// and rounded result register.
// ----------------------------------------------------------------------------
module hbs_dpath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  hbs_pkg::in_item_t                  in_data,
  input  logic [hbs_pkg::GRID_BITS-1:0]     grid_size,
  input  hbs_pkg::cmd_t                      cmd,
  output hbs_pkg::status_t                   status,
  output logic                              out_valid,
  output hbs_pkg::out_item_t                 out_data
);
  import hbs_pkg::*;

  logic [HEIGHT_BITS-1:0] mem [MAX_SIDE*MAX_SIDE];

  logic [SIDE_BITS-1:0]   row_r, col_r;
  logic [FRAC_BITS-1:0]   fx_r, fy_r;
  logic                   in_range_r;
  logic [HEIGHT_BITS-1:0] rdata_r;
  logic [WEIGHT_BITS-1:0] w_r;
  logic [ACC_BITS-1:0]    prod_r, acc_r;
  logic                   out_valid_r;
  out_item_t              out_r;

  logic [GRID_BITS-1:0]   side, lim;
  logic                   in_range_nxt;
  logic [SIDE_BITS:0]     rd_row, rd_col;
  logic [ADDR_BITS-1:0]   rd_addr, mem_addr;
  logic [FRAC_BITS:0]     fa, fb;
  logic [2*FRAC_BITS+1:0] weight;
  logic [HEIGHT_BITS-1:0] biased;
  logic [HEIGHT_BITS+WEIGHT_BITS-1:0] prod_full;
  logic [ACC_BITS:0]      rnd;
  logic [HEIGHT_BITS-1:0] val;

  always_comb begin
    if (grid_size < GRID_MIN) begin
      side = GRID_MIN;
    end else if (grid_size > GRID_MAX) begin
      side = GRID_MAX;
    end else begin
      side = grid_size;
    end
    lim = side - GRID_MIN;
    in_range_nxt = !in_data.pos_x[POS_BITS-1] && !in_data.pos_y[POS_BITS-1] &&
      ({1'b0, in_data.pos_x[FRAC_BITS+SIDE_BITS-1:FRAC_BITS]} <= lim) &&
      ({1'b0, in_data.pos_y[FRAC_BITS+SIDE_BITS-1:FRAC_BITS]} <= lim);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      row_r      <= in_data.pos_x[FRAC_BITS+SIDE_BITS-1:FRAC_BITS];
      col_r      <= in_data.pos_y[FRAC_BITS+SIDE_BITS-1:FRAC_BITS];
      fx_r       <= in_data.pos_x[FRAC_BITS-1:0];
      fy_r       <= in_data.pos_y[FRAC_BITS-1:0];
      in_range_r <= in_range_nxt;
    end
  end

  assign status.in_range = in_range_r;

  // corner k: row + k[1], col + k[0]
  always_comb begin
    rd_row   = {1'b0, row_r} + {{SIDE_BITS{1'b0}}, cmd.corner[1]};
    rd_col   = {1'b0, col_r} + {{SIDE_BITS{1'b0}}, cmd.corner[0]};
    rd_addr  = {rd_row[SIDE_BITS-1:0], rd_col[SIDE_BITS-1:0]};
    mem_addr = cmd.mem_wr ? {in_data.write_row, in_data.write_col} : rd_addr;
    fa = cmd.corner[1] ? {1'b0, fx_r} : (9'(1 << FRAC_BITS) - {1'b0, fx_r});
    fb = cmd.corner[0] ? {1'b0, fy_r} : (9'(1 << FRAC_BITS) - {1'b0, fy_r});
    weight = fa * fb;
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      mem[mem_addr] <= in_data.write_height;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[mem_addr];
      w_r     <= weight[WEIGHT_BITS-1:0];
    end
  end

  // offset-binary height times weight
  assign biased    = rdata_r ^ {1'b1, {(HEIGHT_BITS-1){1'b0}}};
  assign prod_full = biased * w_r;

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r <= prod_full[ACC_BITS-1:0];
    end
    if (cmd.load) begin
      acc_r <= '0;
    end else if (cmd.acc_en) begin
      acc_r <= acc_r + prod_r;
    end
  end

  always_comb begin
    rnd = {1'b0, acc_r} + (ACC_BITS+1)'(1 << (2*FRAC_BITS-1));
    val = rnd[ACC_BITS-1:2*FRAC_BITS];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.out_en;
    end
    if (cmd.out_en) begin
      if (in_range_r) begin
        out_r.height   <= val ^ {1'b1, {(HEIGHT_BITS-1){1'b0}}};
        out_r.in_range <= 1'b1;
      end else begin
        out_r <= '0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held for more than one cycle");

  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.in_range) |-> (out_r.height == '0))
    else $error("out-of-range result carries a nonzero height");

endmodule
